// ----- design/bf33_pkg.sv -----
// Shared constants and helpers for the 3x3 box filter with border copy.
// Has no dependencies. Used by box_filter_3x3_border_copy.
package bf33_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;

    localparam int PIX_W  = 8;
    localparam int POS_W  = 9;
    localparam int ADDR_W = $clog2(MAX_COLUMNS);
    localparam int SUM_W  = 12;

    // floor(s / 9) == (s * 3641) >> 15 for every s below 2^15.
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 15;
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(3641);
    localparam int PROD_W = SUM_W + RECIP_W;

    localparam logic [POS_W-1:0] SIZE_MIN   = POS_W'(3);
    localparam logic [POS_W-1:0] COLS_MAX   = POS_W'(MAX_COLUMNS);
    localparam logic [POS_W-1:0] ROWS_MAX   = POS_W'(MAX_ROWS);
    localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(1);
    localparam logic [POS_W-1:0] WIDTH_RST  = POS_W'(140);
    localparam logic [POS_W-1:0] HEIGHT_RST = POS_W'(107);

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    function automatic logic [POS_W-1:0] clamp_size(input logic [POS_W-1:0] v,
                                                    input logic [POS_W-1:0] hi);
        logic [POS_W-1:0] res;
        res = v;
        if (v < SIZE_MIN) begin
            res = SIZE_MIN;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

// ----- design/box_filter_3x3_border_copy.sv -----
// Top level of the streaming 3x3 box filter with border copy.
// Depends on bf33_pkg for sizes, reciprocal constant and register indexes.
//
// Channel  Direction  Signals                                   Payload
// s_axis   in         s_axis_tvalid/tready/tdata                pixel_in
// m_axis   out        m_axis_tvalid/tready/tdata/tlast          row, column, value
// cfg      in         i_cfg_valid/o_cfg_ready/index/data        frame_width, frame_height
//
// A pixel is taken every cycle while results flow; pixels that cause two results
// (the last row and the last column) hold the output register until both are taken.
// From input transfer to result, the line store read, the window update with sum
// and the multiply by the reciprocal of nine are each registered in turn.
// Synchronous active-low reset presets counters and sizes, clears window and valid flags.
// A stall on m_axis backs up through the pipeline to s_axis_tready.
module box_filter_3x3_border_copy (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [8:0] out_row, [17:9] out_column, [25:18] out_value
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int PW = bf33_pkg::PIX_W;
    localparam int QW = bf33_pkg::POS_W;
    localparam int AW = bf33_pkg::ADDR_W;
    localparam int SW = bf33_pkg::SUM_W;

    logic [QW-1:0] r_frame_width;
    logic [QW-1:0] r_frame_height;
    logic [QW-1:0] r_row;
    logic [QW-1:0] r_col;

    logic [PW-1:0] r_mem_older [bf33_pkg::MAX_COLUMNS];
    logic [PW-1:0] r_mem_newer [bf33_pkg::MAX_COLUMNS];
    logic [PW-1:0] r_rd_older;
    logic [PW-1:0] r_rd_newer;
    logic [PW-1:0] r_win [9];

    logic          r_s1_v;
    logic [PW-1:0] r_s1_pix;
    logic [QW-1:0] r_s1_row;
    logic [QW-1:0] r_s1_col;
    logic          r_s1_inner;
    logic          r_s1_border;

    logic          r_s2_v;
    logic [PW-1:0] r_s2_pix;
    logic [QW-1:0] r_s2_row;
    logic [QW-1:0] r_s2_col;
    logic          r_s2_inner;
    logic          r_s2_border;
    logic [SW-1:0] r_s2_sum;

    logic          r_a_v;
    logic [QW-1:0] r_a_row;
    logic [QW-1:0] r_a_col;
    logic [PW-1:0] r_a_val;
    logic          r_b_v;
    logic [QW-1:0] r_b_row;
    logic [QW-1:0] r_b_col;
    logic [PW-1:0] r_b_val;

    logic [QW-1:0] w_eff;
    logic [QW-1:0] h_eff;
    logic [QW-1:0] c_eff;
    logic [QW-1:0] r_eff;
    logic [QW-1:0] n_row;
    logic [QW-1:0] n_col;
    logic          in_fire;
    logic          s1_move;
    logic          s2_move;
    logic          s2_ready;
    logic          s3_ready;
    logic          out_fire;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] new_sum;
    logic [bf33_pkg::PROD_W-1:0] prod;

    assign o_cfg_ready = 1'b1;

    assign w_eff = bf33_pkg::clamp_size(r_frame_width, bf33_pkg::COLS_MAX);
    assign h_eff = bf33_pkg::clamp_size(r_frame_height, bf33_pkg::ROWS_MAX);
    assign c_eff = (r_col > w_eff) ? w_eff : r_col;
    assign r_eff = (r_row > h_eff) ? h_eff : r_row;
    assign rd_addr = AW'(c_eff - bf33_pkg::POS_FIRST);
    assign wr_addr = AW'(r_s1_col - bf33_pkg::POS_FIRST);

    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s3_ready = (!r_a_v && !r_b_v) || (out_fire && !(r_a_v && r_b_v));
    assign s2_ready = !r_s2_v || s3_ready;
    assign s2_move  = r_s2_v && s3_ready;
    assign s1_move  = r_s1_v && s2_ready;
    assign s_axis_tready = !r_s1_v || s2_ready;
    assign in_fire  = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (c_eff >= w_eff) begin
            n_col = bf33_pkg::POS_FIRST;
            n_row = (r_eff >= h_eff) ? bf33_pkg::POS_FIRST : r_eff + bf33_pkg::POS_FIRST;
        end else begin
            n_col = c_eff + bf33_pkg::POS_FIRST;
            n_row = r_eff;
        end
    end

    always_comb begin
        new_sum = SW'(r_win[1]) + SW'(r_win[2]) + SW'(r_rd_older)
                + SW'(r_win[4]) + SW'(r_win[5]) + SW'(r_rd_newer)
                + SW'(r_win[7]) + SW'(r_win[8]) + SW'(r_s1_pix);
    end

    assign prod = bf33_pkg::PROD_W'(r_s2_sum) * bf33_pkg::PROD_W'(bf33_pkg::RECIP_9);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bf33_pkg::WIDTH_RST;
            r_frame_height <= bf33_pkg::HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bf33_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                bf33_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_older <= r_mem_older[rd_addr];
            r_rd_newer <= r_mem_newer[rd_addr];
        end
        if (s1_move) begin
            r_mem_older[wr_addr] <= r_rd_newer;
            r_mem_newer[wr_addr] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= bf33_pkg::POS_FIRST;
            r_col  <= bf33_pkg::POS_FIRST;
            r_s1_v <= 1'b0;
        end else begin
            if (in_fire) begin
                r_row  <= n_row;
                r_col  <= n_col;
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix    <= s_axis_tdata;
            r_s1_row    <= r_eff;
            r_s1_col    <= c_eff;
            r_s1_inner  <= (r_eff >= bf33_pkg::SIZE_MIN) && (c_eff >= bf33_pkg::SIZE_MIN);
            r_s1_border <= (r_eff == bf33_pkg::POS_FIRST) || (r_eff == h_eff)
                        || (c_eff == bf33_pkg::POS_FIRST) || (c_eff == w_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
            r_s2_v <= 1'b0;
        end else begin
            if (s1_move) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= r_rd_older;
                r_win[5] <= r_rd_newer;
                r_win[8] <= r_s1_pix;
                r_s2_v   <= 1'b1;
            end else if (s2_move) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_pix    <= r_s1_pix;
            r_s2_row    <= r_s1_row;
            r_s2_col    <= r_s1_col;
            r_s2_inner  <= r_s1_inner;
            r_s2_border <= r_s1_border;
            r_s2_sum    <= new_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (s2_move) begin
            r_a_v <= r_s2_inner;
            r_b_v <= r_s2_border;
        end else if (out_fire) begin
            if (r_a_v) begin
                r_a_v <= 1'b0;
            end else begin
                r_b_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_a_row <= r_s2_row - bf33_pkg::POS_FIRST;
            r_a_col <= r_s2_col - bf33_pkg::POS_FIRST;
            r_a_val <= prod[bf33_pkg::RECIP_SHIFT +: PW];
            r_b_row <= r_s2_row;
            r_b_col <= r_s2_col;
            r_b_val <= r_s2_pix;
        end
    end

    always_comb begin
        m_axis_tvalid = r_a_v || r_b_v;
        if (r_a_v) begin
            m_axis_tdata = {6'b0, r_a_val, r_a_col, r_a_row};
            m_axis_tlast = !r_b_v;
        end else begin
            m_axis_tdata = {6'b0, r_b_val, r_b_col, r_b_row};
            m_axis_tlast = 1'b1;
        end
    end

endmodule

// ----- tb/sv/box_filter_3x3_border_copy_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for box_filter_3x3_border_copy: streams frames of pixels,
// predicts every filtered or border result and compares it on the output stream.
// Depends on bf33_pkg for sizes and register indexes.
module box_filter_3x3_border_copy_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [8:0] row;
        logic [8:0] col;
        logic [7:0] value;
        logic       last;
    } t_out_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [8:0]  i_cfg_data;

    box_filter_3x3_border_copy dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // Filter state as the block should hold it.
    logic [8:0] cfg_width;
    logic [8:0] cfg_height;
    logic [7:0] rows_older[bf33_pkg::MAX_COLUMNS];
    logic [7:0] rows_newer[bf33_pkg::MAX_COLUMNS];
    logic [7:0] window[9];
    int         row_pos;
    int         col_pos;

    t_out_pixel filtered_due[$];
    int         src_idle_pct;
    int         sink_idle_pct;
    int         pixels_sent;
    int         results_seen;
    int         frames_done;
    int         bad_results;
    int         stall_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int size_limit(input logic [8:0] v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void filter_pixel(input logic [7:0] pix);
        int w, h, r, c, sum, k;
        logic [7:0] up2, up1;
        logic has_inner, has_edge;
        t_out_pixel item;
        w = size_limit(cfg_width, bf33_pkg::MAX_COLUMNS);
        h = size_limit(cfg_height, bf33_pkg::MAX_ROWS);
        r = (row_pos > h) ? h : row_pos;
        c = (col_pos > w) ? w : col_pos;
        up2 = rows_older[c - 1];
        up1 = rows_newer[c - 1];
        rows_older[c - 1] = up1;
        rows_newer[c - 1] = pix;
        for (k = 0; k < 3; k++) begin
            window[k * 3] = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2] = up2;
        window[5] = up1;
        window[8] = pix;
        has_inner = (r >= 3) && (c >= 3);
        has_edge = (r == 1) || (r == h) || (c == 1) || (c == w);
        if (has_inner) begin
            sum = 0;
            for (k = 0; k < 9; k++) sum += window[k];
            item.row = 9'(r - 1);
            item.col = 9'(c - 1);
            item.value = 8'(sum / 9);
            item.last = !has_edge;
            filtered_due.push_back(item);
        end
        if (has_edge) begin
            item.row = 9'(r);
            item.col = 9'(c);
            item.value = pix;
            item.last = 1'b1;
            filtered_due.push_back(item);
        end
        if (c >= w) begin
            col_pos = 1;
            if (r >= h) begin
                row_pos = 1;
                frames_done++;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    task automatic push_pixel(input logic [7:0] pix);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        filter_pixel(pix);
        pixels_sent++;
    endtask

    task automatic finish_frame();
        do push_pixel(8'($urandom_range(255))); while (!(row_pos == 1 && col_pos == 1));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        wait (filtered_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == bf33_pkg::CFG_FRAME_WIDTH) begin
            cfg_width = value;
        end else begin
            cfg_height = value;
        end
        @(posedge i_clk);
    endtask

    // Starts at the reset size, then shrinks both sizes below the minimum in the
    // middle of the first row so that the column counter saturates.
    task automatic test_border_and_shrink();
        int i;
        push_pixel(8'h00);
        push_pixel(8'hFF);
        push_pixel(8'h5A);
        wait_idle();
        write_reg(bf33_pkg::CFG_FRAME_WIDTH, 9'd0);
        write_reg(bf33_pkg::CFG_FRAME_HEIGHT, 9'd2);
        push_pixel(8'hA5);
        for (i = 0; i < 6; i++) push_pixel((i % 2) ? 8'hFF : 8'h00);
        wait_idle();
    endtask

    task automatic test_saturated_frame();
        write_reg(bf33_pkg::CFG_FRAME_WIDTH, 9'd3);
        write_reg(bf33_pkg::CFG_FRAME_HEIGHT, 9'd3);
        repeat (9) push_pixel(8'hFF);
        wait_idle();
    endtask

    // A width above the maximum must not wrap the first row early; the row is then
    // cut and the width shrunk so that the frame ends soon.
    task automatic test_wide_frame();
        write_reg(bf33_pkg::CFG_FRAME_WIDTH, 9'd511);
        write_reg(bf33_pkg::CFG_FRAME_HEIGHT, 9'd3);
        repeat (20) push_pixel(8'($urandom_range(255)));
        wait_idle();
        write_reg(bf33_pkg::CFG_FRAME_WIDTH, 9'd5);
        finish_frame();
        wait_idle();
    endtask

    // A height above the maximum must not wrap the frame early; the height is then
    // shrunk so that the row counter saturates on the last row.
    task automatic test_tall_frame();
        write_reg(bf33_pkg::CFG_FRAME_WIDTH, 9'd3);
        write_reg(bf33_pkg::CFG_FRAME_HEIGHT, 9'd511);
        repeat (12) push_pixel(8'($urandom_range(255)));
        wait_idle();
        write_reg(bf33_pkg::CFG_FRAME_HEIGHT, 9'd4);
        finish_frame();
        wait_idle();
    endtask

    // Random small frames; some are cut short, shrunk while idle and then completed.
    task automatic test_random_frames(input int quota);
        int start_count, w, h, cut;
        start_count = pixels_sent;
        while (pixels_sent - start_count < quota) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 7);
            write_reg(bf33_pkg::CFG_FRAME_WIDTH, 9'(w));
            write_reg(bf33_pkg::CFG_FRAME_HEIGHT, 9'(h));
            if ($urandom_range(3) == 0) begin
                cut = $urandom_range(1, w * h - 1);
                repeat (cut) push_pixel(8'($urandom_range(255)));
                wait_idle();
                if ($urandom_range(1)) begin
                    write_reg(bf33_pkg::CFG_FRAME_WIDTH, 9'($urandom_range(0, w)));
                end else begin
                    write_reg(bf33_pkg::CFG_FRAME_HEIGHT, 9'($urandom_range(0, h)));
                end
            end
            finish_frame();
            wait_idle();
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_pixel got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got.row = m_axis_tdata[8:0];
            got.col = m_axis_tdata[17:9];
            got.value = m_axis_tdata[25:18];
            got.last = m_axis_tlast;
            if (filtered_due.size() == 0) begin
                bad_results++;
                $display("%0t: unexpected result row %0d col %0d value %0d last %0b",
                         $time, got.row, got.col, got.value, got.last);
            end else begin
                want = filtered_due.pop_front();
                if (got !== want) begin
                    bad_results++;
                    $display("%0t: expected row %0d col %0d value %0d last %0b",
                             $time, want.row, want.col, want.value, want.last);
                    $display("%0t: actual   row %0d col %0d value %0d last %0b",
                             $time, got.row, got.col, got.value, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= bf33_pkg::CFG_FRAME_WIDTH;
        i_cfg_data <= 9'd0;
        cfg_width = 9'd140;
        cfg_height = 9'd107;
        foreach (rows_older[i]) begin
            rows_older[i] = 8'h00;
            rows_newer[i] = 8'h00;
        end
        foreach (window[i]) window[i] = 8'h00;
        row_pos = 1;
        col_pos = 1;
        pixels_sent = 0;
        results_seen = 0;
        frames_done = 0;
        bad_results = 0;
        src_idle_pct = 37;
        sink_idle_pct = 83;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_border_and_shrink();
        test_saturated_frame();
        test_random_frames(35);

        src_idle_pct = 83;
        sink_idle_pct = 37;
        test_wide_frame();
        test_random_frames(35);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_tall_frame();
        test_random_frames(35);

        wait_idle();
        $display("Streamed %0d pixels in %0d frames and checked %0d results,", pixels_sent,
                 frames_done, results_seen);
        $display("with sizes clamped from below and above and shrunk in mid-frame.");
        if (bad_results == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/bf33_pkg.sv
design/box_filter_3x3_border_copy.sv
tb/sv/box_filter_3x3_border_copy_tb.sv
